// File: hw/rtl/bdq_pkg.sv
// shared types and constants for the bounded double-ended queue
package bdq_pkg;

    // fixed field widths of the command and result transactions
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // width of the sign-extended word between field and storage
    localparam int WIDE_W = 64;

    // default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_READ       = 3'd4
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_INDEX_OOB = 2'd2,
        ST_PUSH_FULL = 2'd3
    } t_status;

    // command transaction
    typedef struct packed {
        t_mode                     mode;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_cmd;

    // result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_res;

endpackage

// File: hw/rtl/bounded_deque_top.sv
// bounded double-ended queue of signed words kept in a ring memory
//
// Usage:
//   A command transaction (mode, value, index) is taken at a rising edge
//   where start is high and busy is low. Modes: push front, push back,
//   pop front, pop back, read at an index counted from the front.
//   Each command gives exactly one result transaction (data, status,
//   count, is_empty), shown on o_res for one cycle with o_strobe high,
//   in the cycle right after the command was taken.
//   Latency is one cycle, and a new command may be taken every cycle:
//   each command does one access to the single-port ring memory (one
//   write for a push, one registered read for a pop or a read), and the
//   pointer and count registers update at the edge that takes it.
//   Errors (pop on empty, index out of bounds, push on full) leave the
//   state untouched and report data 0 with an error status.
//   Reset (synchronous, active low) empties the queue and holds busy
//   high while asserted and for the first cycle after release; the ring
//   contents are not cleared, only entries below the count are ever read.
//   The receiver cannot stall: a result is taken at the edge that ends
//   its strobe cycle.
module bounded_deque_top #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bdq_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output bdq_pkg::t_res o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > bdq_pkg::INDEX_W) ? CNT_W : bdq_pkg::INDEX_W;

    // ring memory and control state
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [PTR_W-1:0]      r_front;
    logic [PTR_W-1:0]      n_front;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_busy;
    logic                  r_strobe;
    logic                  r_rd_sel;
    logic                  n_rd_sel;
    bdq_pkg::t_status      r_status;
    bdq_pkg::t_status      n_status;

    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          wr_en;
    logic [PTR_W-1:0]              addr;
    logic [DATA_WIDTH-1:0]         wr_word;
    logic [bdq_pkg::WIDE_W-1:0]    wide_in;
    logic signed [bdq_pkg::WIDE_W-1:0] wide_out;
    logic signed [DATA_WIDTH-1:0]  rd_signed;

    // ring position of an offset from the given front, one compare and subtract
    function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] front,
                                                  input logic [PTR_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, front} + {1'b0, offset};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    // push word: sign-extend the field, keep the storage width
    assign wide_in = bdq_pkg::WIDE_W'(i_cmd.value);
    assign wr_word = wide_in[DATA_WIDTH-1:0];

    // operation decode: next state, memory address and status
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = bdq_pkg::ST_OK;
        n_rd_sel = 1'b0;
        wr_en    = 1'b0;
        addr     = r_front;
        case (i_cmd.mode)
            bdq_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_PUSH_FULL;
                end else begin
                    n_front = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - 1'b1;
                    addr    = n_front;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    n_status = bdq_pkg::ST_PUSH_FULL;
                end else begin
                    addr    = ring_pos(r_front, PTR_W'(r_count));
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_POP_EMPTY;
                end else begin
                    addr     = r_front;
                    n_rd_sel = 1'b1;
                    n_front  = ring_pos(r_front, PTR_W'(1));
                    n_count  = r_count - 1'b1;
                end
            end
            bdq_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_POP_EMPTY;
                end else begin
                    addr     = ring_pos(r_front, PTR_W'(r_count - 1'b1));
                    n_rd_sel = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            bdq_pkg::MODE_READ: begin
                if (CMP_W'(i_cmd.index) >= CMP_W'(r_count)) begin
                    n_status = bdq_pkg::ST_INDEX_OOB;
                end else begin
                    addr     = ring_pos(r_front, PTR_W'(i_cmd.index));
                    n_rd_sel = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ring memory: at most one write or one registered read per transaction
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[addr] <= wr_word;
        end
        if (accept && n_rd_sel) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_rd_sel <= 1'b0;
            r_status <= bdq_pkg::ST_OK;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_front  <= n_front;
                r_count  <= n_count;
                r_rd_sel <= n_rd_sel;
                r_status <= n_status;
            end
        end
    end

    // result transaction
    assign rd_signed = r_rd_data;
    assign wide_out  = bdq_pkg::WIDE_W'(rd_signed);

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_res.data     = r_rd_sel ? wide_out[bdq_pkg::DATA_W-1:0] : '0;
    assign o_res.status   = r_status;
    assign o_res.count    = bdq_pkg::COUNT_W'(r_count);
    assign o_res.is_empty = (r_count == '0);

    // count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // one result per accepted command, in the next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result strobe without command");

    // dropped push leaves the queue untouched
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (i_cmd.mode == bdq_pkg::MODE_PUSH_FRONT
                           || i_cmd.mode == bdq_pkg::MODE_PUSH_BACK)
        |=> (o_res.status == bdq_pkg::ST_PUSH_FULL) && $stable(r_count)
            && $stable(r_front))
        else $error("push on full changed state");

    // successful pop removes exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !empty && (i_cmd.mode == bdq_pkg::MODE_POP_FRONT
                             || i_cmd.mode == bdq_pkg::MODE_POP_BACK)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not remove one entry");

endmodule

// File: tb/bounded_deque_top_test.sv
// self-checking testbench for the bounded double-ended queue top level
module bounded_deque_top_test;
    import bdq_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int RING_DEPTH    = DEPTH_DEF;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_LIMIT   = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // a mode outside the defined operations, which must leave the queue alone
    localparam t_mode MODE_UNUSED = t_mode'(3'd7);

    // one line of the directed stimulus table
    typedef struct {
        t_cmd cmd;
        int   reps;
        bit   pinned;
        t_res res;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_strobe;
    t_res o_res;

    // expectation typed into the table travels with its command
    bit   pin_valid = 1'b0;
    t_res pin_res   = '0;

    // shadow copy of the queue contents
    logic signed [DATA_W-1:0] q_ring [RING_DEPTH];
    logic [3:0]               q_front = '0;
    logic [COUNT_W-1:0]       q_count = '0;

    t_res res_expected [$];
    int   err_count   = 0;
    int   n_accepted  = 0;
    int   n_checked   = 0;
    int   n_full      = 0;
    int   n_pop_empty = 0;
    int   n_oob       = 0;
    int   cycle_cnt;

    bounded_deque_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // apply one operation to the shadow queue and return its result
    function automatic t_res deque_apply(t_cmd c);
        t_res       r;
        logic [3:0] pos;
        r = '0;
        r.status = ST_OK;
        case (c.mode)
            MODE_PUSH_FRONT: begin
                if (q_count == RING_DEPTH) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    q_front = q_front - 4'd1;
                    q_ring[q_front] = c.value;
                    q_count = q_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (q_count == RING_DEPTH) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    pos = q_front + q_count[3:0];
                    q_ring[pos] = c.value;
                    q_count = q_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (q_count == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    r.data = q_ring[q_front];
                    q_front = q_front + 4'd1;
                    q_count = q_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (q_count == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    pos = q_front + q_count[3:0] - 4'd1;
                    r.data = q_ring[pos];
                    q_count = q_count - 1'b1;
                end
            end
            MODE_READ: begin
                if (c.index >= q_count) begin
                    r.status = ST_INDEX_OOB;
                end else begin
                    pos = q_front + c.index[3:0];
                    r.data = q_ring[pos];
                end
            end
            default: ;
        endcase
        r.count    = q_count;
        r.is_empty = (q_count == 0);
        return r;
    endfunction

    function automatic t_stim_row stim_row(t_mode m, logic [VALUE_W-1:0] v,
                                           logic [INDEX_W-1:0] idx, int n, bit pinned,
                                           logic [DATA_W-1:0] d, t_status st,
                                           logic [COUNT_W-1:0] cnt);
        t_stim_row s;
        s.cmd.mode      = m;
        s.cmd.value     = v;
        s.cmd.index     = idx;
        s.reps          = n;
        s.pinned        = pinned;
        s.res.data      = d;
        s.res.status    = st;
        s.res.count     = cnt;
        s.res.is_empty  = (cnt == 0);
        return s;
    endfunction

    // random idle burst before a command, or none
    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    // present one command and hold it until the block takes it
    task automatic send_cmd(t_cmd c, int gap, bit pinned, t_res res);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= c;
        pin_valid <= pinned;
        pin_res   <= res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // check results against pending expectations, then predict new commands
    always @(posedge i_clk) begin
        t_res want;
        t_res model_res;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (res_expected.size() == 0) begin
                    err_count++;
                    $error("result transaction with no pending expectation");
                end else begin
                    want = res_expected.pop_front();
                    n_checked++;
                    if (o_res.data !== want.data) begin
                        err_count++;
                        $error("data: expected %0d, got %0d", want.data, o_res.data);
                    end
                    if (o_res.status !== want.status) begin
                        err_count++;
                        $error("status: expected %0d, got %0d", want.status, o_res.status);
                    end
                    if (o_res.count !== want.count) begin
                        err_count++;
                        $error("count: expected %0d, got %0d", want.count, o_res.count);
                    end
                    if (o_res.is_empty !== want.is_empty) begin
                        err_count++;
                        $error("is_empty: expected %0d, got %0d", want.is_empty,
                               o_res.is_empty);
                    end
                end
            end
            if (start && !busy) begin
                model_res = deque_apply(i_cmd);
                res_expected.push_back(pin_valid ? pin_res : model_res);
                n_accepted++;
                case (model_res.status)
                    ST_PUSH_FULL: n_full++;
                    ST_POP_EMPTY: n_pop_empty++;
                    ST_INDEX_OOB: n_oob++;
                    default: ;
                endcase
            end
        end
    end

    // watchdog
    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        t_stim_row stim_table [$];
        t_cmd      cmd;
        int        push_pct;
        int        pop_pct;
        int        pick;
        int        drain;
        bit        idle_on;

        // directed: empty errors, unused mode, extremes, boundary reads, fill to full, pushes on full, pops
        stim_table.push_back(stim_row(MODE_POP_FRONT, '0, '0, 1, 1, '0, ST_POP_EMPTY, 0));
        stim_table.push_back(stim_row(MODE_POP_BACK, '0, '0, 1, 1, '0, ST_POP_EMPTY, 0));
        stim_table.push_back(stim_row(MODE_READ, '0, '0, 1, 1, '0, ST_INDEX_OOB, 0));
        stim_table.push_back(stim_row(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, '0,
                                      ST_OK, 0));
        stim_table.push_back(stim_row(MODE_PUSH_FRONT, 32'h8000_0000, '0, 1, 1, '0,
                                      ST_OK, 1));
        stim_table.push_back(stim_row(MODE_PUSH_BACK, 32'h7FFF_FFFF, '0, 1, 1, '0,
                                      ST_OK, 2));
        stim_table.push_back(stim_row(MODE_READ, '0, 16'd0, 1, 1, 32'h8000_0000, ST_OK, 2));
        stim_table.push_back(stim_row(MODE_READ, '0, 16'd1, 1, 1, 32'h7FFF_FFFF, ST_OK, 2));
        stim_table.push_back(stim_row(MODE_READ, '0, 16'd2, 1, 1, '0, ST_INDEX_OOB, 2));
        stim_table.push_back(stim_row(MODE_READ, '0, 16'hFFFF, 1, 1, '0, ST_INDEX_OOB, 2));
        stim_table.push_back(stim_row(MODE_PUSH_FRONT, 32'h5A5A_A5A5, '0, 7, 0, '0,
                                      ST_OK, 0));
        stim_table.push_back(stim_row(MODE_PUSH_BACK, 32'hC3C3_3C3C, '0, 7, 0, '0,
                                      ST_OK, 0));
        stim_table.push_back(stim_row(MODE_PUSH_FRONT, 32'h1234_5678, '0, 1, 1, '0,
                                      ST_PUSH_FULL, COUNT_W'(RING_DEPTH)));
        stim_table.push_back(stim_row(MODE_PUSH_BACK, 32'h8765_4321, '0, 1, 1, '0,
                                      ST_PUSH_FULL, COUNT_W'(RING_DEPTH)));
        stim_table.push_back(stim_row(MODE_READ, '0, INDEX_W'(RING_DEPTH - 1), 1, 0, '0,
                                      ST_OK, 0));
        stim_table.push_back(stim_row(MODE_POP_FRONT, '0, '0, 1, 0, '0, ST_OK, 0));
        stim_table.push_back(stim_row(MODE_POP_BACK, '0, '0, 1, 0, '0, ST_OK, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            for (int r = 0; r < stim_table[i].reps; r++) begin
                send_cmd(stim_table[i].cmd, pick_gap(), stim_table[i].pinned,
                         stim_table[i].res);
            end
        end

        // random phases biased to fill, drain, mix or read the queue
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: begin push_pct = 60; pop_pct = 20; end
                1: begin push_pct = 20; pop_pct = 60; end
                2: begin push_pct = 40; pop_pct = 40; end
                default: begin push_pct = 30; pop_pct = 20; end
            endcase
            // the closing phases run back to back with no idle cycles
            idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: cmd.value = 32'h8000_0000;
                        1: cmd.value = 32'h7FFF_FFFF;
                        2: cmd.value = 32'h0000_0000;
                        default: cmd.value = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    cmd.value = $urandom;
                end
                if ($urandom_range(0, 6) == 0) begin
                    cmd.index = INDEX_W'($urandom);
                end else begin
                    cmd.index = INDEX_W'($urandom_range(0, RING_DEPTH + 1));
                end
                if (pick == 0) begin
                    cmd.mode = MODE_UNUSED;
                end else if (pick <= push_pct) begin
                    cmd.mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                end else if (pick <= push_pct + pop_pct) begin
                    cmd.mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                end else begin
                    cmd.mode = MODE_READ;
                end
                send_cmd(cmd, idle_on ? pick_gap() : 0, 1'b0, '0);
            end
        end

        // wait for outstanding results, then a short settle
        start <= 1'b0;
        @(posedge i_clk);
        drain = 0;
        while (res_expected.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (res_expected.size() != 0) begin
            err_count++;
            $error("%0d expected results never arrived", res_expected.size());
        end

        $display("sent %0d commands and checked %0d results", n_accepted, n_checked);
        $display("covered %0d pushes on full, %0d pops on empty, %0d out-of-range reads",
                 n_full, n_pop_empty, n_oob);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
